>>> hdl/hkre_pkg.sv
package hkre_pkg;

	localparam int MOD_BITS     = 8;
	localparam int INPUT_SLOTS  = 6;
	localparam int KEY_ROM_SIZE = 112;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [7:0] KEY_ROM [KEY_ROM_SIZE] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
		8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
		8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
		8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
		8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
		8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
		8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
		8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
		8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd70,  8'd71,
		8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106, 8'd108,
		8'd105, 8'd103, 8'd98,  8'd69,  8'd55,  8'd74,  8'd78,  8'd96,
		8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd72,  8'd73,
		8'd82,  8'd71,  8'd83,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
	};

	localparam logic [7:0] MOD_ROM [MOD_BITS] = '{
		8'h1D, 8'h2A, 8'h38, 8'hDB, 8'h9D, 8'h36, 8'hB8, 8'hDC
	};

	typedef struct packed {
		logic       rel_hit;
		logic [7:0] rel_code;
		logic       prs_hit;
		logic [7:0] prs_code;
	} hkre_lane_t;

	function automatic logic [7:0] key_map(input logic [7:0] usage, input int entries);
		logic [7:0] code;
		if (int'(usage) >= entries || int'(usage) >= KEY_ROM_SIZE) begin
			code = 8'd0;
		end else begin
			code = KEY_ROM[usage[6:0]];
		end
		return code;
	endfunction

endpackage

>>> hdl/hkre_if.sv
interface hkre_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] modifiers;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, command, modifiers,
		output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);
	modport sink (
		input  valid, command, modifiers,
		input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

interface hkre_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;
	logic       pressed;
	logic       last_event;

	modport source (output valid, scancode, pressed, last_event, input ready);
	modport sink (input valid, scancode, pressed, last_event, output ready);
endinterface

>>> hdl/hid_keyboard_report_to_key_events_top.sv
// Turns boot keyboard reports into set-1 key events. Each report is compared with
// the one kept from before: changed modifier bits come out first (bit 0 up), then
// releases of keys that left the report, then presses of new keys, slot 0 first
// in each group; last_event marks the final event of a report, and a report with
// no change or a clear command gives no event. One lane per key slot checks its
// slot against the other report in the accept cycle; the event set is then held
// in one stage and handed to an output queue that sends one event per cycle while
// the receiver is ready. A report is taken in any cycle in which the middle stage
// is empty or hands its events to the output queue; a report gives at most 20
// events with six slots, and reports with no event pass at one per cycle while
// the middle stage is empty. A report's events are registered in the middle stage
// and then in the output queue before the first can be taken, and the next report
// waits in the middle stage while events drain.
module hid_keyboard_report_to_key_events_top
	import hkre_pkg::*;
#(
	parameter int KEY_SLOTS   = 6,
	parameter int MAP_ENTRIES = 112
) (
	input  logic       clk,
	input  logic       arst_n,
	hkre_in_if.sink    report,
	hkre_out_if.source key_events
);

	localparam int EVENTS = MOD_BITS + 2 * KEY_SLOTS;

	logic [INPUT_SLOTS-1:0][7:0] slot_in;
	logic [KEY_SLOTS-1:0][7:0]   new_keys;
	logic [KEY_SLOTS-1:0][7:0]   prior_keys_q;
	logic [7:0]                  prior_mods_q;
	hkre_lane_t                  lane_res [KEY_SLOTS];

	logic [EVENTS-1:0]      ev_hit;
	logic [EVENTS-1:0][7:0] ev_code;
	logic [EVENTS-1:0]      ev_down;

	logic                   valid_s1;
	logic [EVENTS-1:0]      hit_s1;
	logic [EVENTS-1:0][7:0] code_s1;
	logic [EVENTS-1:0]      down_s1;

	logic accept;
	logic take_ok;
	logic load;

	assign slot_in = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
			report.key_slot_2, report.key_slot_1, report.key_slot_0};

	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		if (g < INPUT_SLOTS) begin : g_fed
			assign new_keys[g] = slot_in[g];
		end else begin : g_empty
			assign new_keys[g] = 8'd0;
		end
		hkre_lane #(
			.KEY_SLOTS   (KEY_SLOTS),
			.MAP_ENTRIES (MAP_ENTRIES),
			.LANE        (g)
		) u_lane (
			.prior_keys (prior_keys_q),
			.new_keys   (new_keys),
			.lane       (lane_res[g])
		);
	end

	// merge modifier changes and lane results in emit order
	always_comb begin
		for (int b = 0; b < MOD_BITS; b++) begin
			ev_hit[b]  = prior_mods_q[b] ^ report.modifiers[b];
			ev_code[b] = MOD_ROM[b];
			ev_down[b] = report.modifiers[b];
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			ev_hit[MOD_BITS + i]              = lane_res[i].rel_hit;
			ev_code[MOD_BITS + i]             = lane_res[i].rel_code;
			ev_down[MOD_BITS + i]             = 1'b0;
			ev_hit[MOD_BITS + KEY_SLOTS + i]  = lane_res[i].prs_hit;
			ev_code[MOD_BITS + KEY_SLOTS + i] = lane_res[i].prs_code;
			ev_down[MOD_BITS + KEY_SLOTS + i] = 1'b1;
		end
	end

	assign report.ready = !valid_s1 || take_ok;
	assign accept       = report.valid && report.ready;
	assign load         = valid_s1 && take_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			prior_mods_q <= '0;
			prior_keys_q <= '0;
		end else begin
			if (accept) begin
				if (report.command == CMD_CLEAR) begin
					prior_mods_q <= '0;
					prior_keys_q <= '0;
					valid_s1     <= 1'b0;
				end else begin
					prior_mods_q <= report.modifiers;
					prior_keys_q <= new_keys;
					valid_s1     <= |ev_hit;
				end
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1  <= ev_hit;
			code_s1 <= ev_code;
			down_s1 <= ev_down;
		end
	end

	hkre_emit #(
		.EVENTS (EVENTS)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.hit     (hit_s1),
		.code    (code_s1),
		.down    (down_s1),
		.take_ok (take_ok),
		.evt     (key_events)
	);

endmodule

>>> hdl/hkre_lane.sv
module hkre_lane
	import hkre_pkg::*;
#(
	parameter int KEY_SLOTS   = 6,
	parameter int MAP_ENTRIES = 112,
	parameter int LANE        = 0
) (
	input  logic [KEY_SLOTS-1:0][7:0] prior_keys,
	input  logic [KEY_SLOTS-1:0][7:0] new_keys,
	output hkre_lane_t                lane
);

	logic [7:0] prior_key;
	logic [7:0] new_key;
	logic       in_new;
	logic       in_prior;
	logic [7:0] rel_code;
	logic [7:0] prs_code;

	assign prior_key = prior_keys[LANE];
	assign new_key   = new_keys[LANE];

	always_comb begin
		in_new   = 1'b0;
		in_prior = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (new_keys[j] == prior_key) in_new = 1'b1;
			if (prior_keys[j] == new_key) in_prior = 1'b1;
		end
		rel_code = key_map(prior_key, MAP_ENTRIES);
		prs_code = key_map(new_key, MAP_ENTRIES);
		lane.rel_hit  = (prior_key != 8'd0) && !in_new && (rel_code != 8'd0);
		lane.rel_code = rel_code;
		lane.prs_hit  = (new_key != 8'd0) && !in_prior && (prs_code != 8'd0);
		lane.prs_code = prs_code;
	end

endmodule

>>> hdl/hkre_emit.sv
module hkre_emit
	import hkre_pkg::*;
#(
	parameter int EVENTS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [EVENTS-1:0]      hit,
	input  logic [EVENTS-1:0][7:0] code,
	input  logic [EVENTS-1:0]      down,
	output logic                   take_ok,
	hkre_out_if.source             evt
);

	localparam int IW = $clog2(EVENTS);

	logic [EVENTS-1:0]      mask_q;
	logic [EVENTS-1:0][7:0] code_q;
	logic [EVENTS-1:0]      down_q;
	logic [IW-1:0]          sel;
	logic [EVENTS-1:0]      rest;
	logic                   last;

	// lowest pending event goes first
	always_comb begin
		sel = '0;
		for (int i = EVENTS - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = IW'(i);
		end
		rest      = mask_q;
		rest[sel] = 1'b0;
		last      = (rest == '0);
	end

	assign evt.valid      = |mask_q;
	assign evt.scancode   = code_q[sel];
	assign evt.pressed    = down_q[sel];
	assign evt.last_event = last;
	assign take_ok        = !(|mask_q) || (evt.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= hit;
		end else if (evt.valid && evt.ready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= code;
			down_q <= down;
		end
	end

endmodule

>>> test/tb_hid_keyboard_report_to_key_events_top.sv
module tb_hid_keyboard_report_to_key_events_top
	import hkre_pkg::*;
();

	typedef struct packed {
		logic            command;
		logic [7:0]      modifiers;
		logic [5:0][7:0] keys;
	} report_t;

	typedef struct packed {
		logic [7:0] scancode;
		logic       pressed;
		logic       last_event;
	} key_event_t;

	localparam logic [7:0] SET1_CODES [112] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
		8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
		8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
		8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
		8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
		8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
		8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
		8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
		8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd70,  8'd71,
		8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106, 8'd108,
		8'd105, 8'd103, 8'd98,  8'd69,  8'd55,  8'd74,  8'd78,  8'd96,
		8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd72,  8'd73,
		8'd82,  8'd71,  8'd83,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
	};

	localparam logic [7:0] MODIFIER_CODES [8] = '{
		8'h1D, 8'h2A, 8'h38, 8'hDB, 8'h9D, 8'h36, 8'hB8, 8'hDC
	};

	localparam int RANDOM_PER_PHASE = 100;

	logic clk;
	logic arst_n;

	hkre_in_if  report_if();
	hkre_out_if events_if();

	hid_keyboard_report_to_key_events_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.report     (report_if),
		.key_events (events_if)
	);

	report_t    pending_reports[$];
	key_event_t expected_events[$];
	logic [7:0]      held_modifiers;
	logic [5:0][7:0] held_keys;
	bit  report_taken;
	int  sender_idle_pct;
	int  receiver_stall_pct;
	int  error_count;

	always #5 clk = ~clk;

	function automatic logic [7:0] set1_code(input logic [7:0] usage);
		logic [7:0] code;
		if (usage >= 8'd112) begin
			code = 8'd0;
		end else begin
			code = SET1_CODES[usage];
		end
		return code;
	endfunction

	function automatic bit slot_present(input logic [5:0][7:0] list, input logic [7:0] usage);
		bit found;
		found = 0;
		for (int j = 0; j < 6; j++) begin
			if (list[j] == usage) begin
				found = 1;
			end
		end
		return found;
	endfunction

	task automatic predict_key_events(input report_t r);
		logic [7:0] code;
		key_event_t evs[$];
		if (r.command == CMD_CLEAR) begin
			held_modifiers = '0;
			held_keys      = '0;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (held_modifiers[i] != r.modifiers[i]) begin
					evs.push_back('{MODIFIER_CODES[i], r.modifiers[i], 1'b0});
				end
			end
			// releases, then presses, slot 0 first
			for (int i = 0; i < 6; i++) begin
				if (held_keys[i] != 8'd0 && !slot_present(r.keys, held_keys[i])) begin
					code = set1_code(held_keys[i]);
					if (code != 8'd0) begin
						evs.push_back('{code, 1'b0, 1'b0});
					end
				end
			end
			for (int i = 0; i < 6; i++) begin
				if (r.keys[i] != 8'd0 && !slot_present(held_keys, r.keys[i])) begin
					code = set1_code(r.keys[i]);
					if (code != 8'd0) begin
						evs.push_back('{code, 1'b1, 1'b0});
					end
				end
			end
			if (evs.size() > 0) begin
				evs[evs.size() - 1].last_event = 1'b1;
			end
			foreach (evs[k]) begin
				expected_events.push_back(evs[k]);
			end
			held_modifiers = r.modifiers;
			held_keys      = r.keys;
		end
	endtask

	task automatic queue_report(input logic cmd, input logic [7:0] mods,
			input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2,
			input logic [7:0] k3, input logic [7:0] k4, input logic [7:0] k5);
		report_t r;
		r.command   = cmd;
		r.modifiers = mods;
		r.keys      = {k5, k4, k3, k2, k1, k0};
		pending_reports.push_back(r);
	endtask

	// mostly typing-like changes from the previous report, some noise and clears
	function automatic report_t next_report(input report_t prev);
		report_t r;
		int pick;
		pick = $urandom_range(99);
		r.command = CMD_REPORT;
		if (pick < 4) begin
			r.command   = CMD_CLEAR;
			r.modifiers = 8'($urandom);
			r.keys      = 48'({$urandom, $urandom});
		end else if (pick < 14) begin
			r.modifiers = 8'($urandom);
			r.keys      = 48'({$urandom, $urandom});
		end else begin
			r.modifiers = prev.modifiers;
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(5) == 0) begin
					r.modifiers[i] = ~prev.modifiers[i];
				end
			end
			for (int i = 0; i < 6; i++) begin
				case ($urandom_range(11))
					0, 1, 2, 3, 4, 5, 6: r.keys[i] = prev.keys[i];
					7, 8:                r.keys[i] = 8'd0;
					9, 10:               r.keys[i] = 8'($urandom_range(98, 4));
					default:             r.keys[i] = 8'($urandom_range(255));
				endcase
			end
			if ($urandom_range(9) == 0) begin
				r.keys[$urandom_range(5)] = r.keys[$urandom_range(5)];
			end
		end
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		report_t cur;
		if (arst_n) begin
			if (!report_if.valid || report_taken) begin
				report_taken = 0;
				if (pending_reports.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					cur = pending_reports.pop_front();
					report_if.valid      <= 1'b1;
					report_if.command    <= cur.command;
					report_if.modifiers  <= cur.modifiers;
					report_if.key_slot_0 <= cur.keys[0];
					report_if.key_slot_1 <= cur.keys[1];
					report_if.key_slot_2 <= cur.keys[2];
					report_if.key_slot_3 <= cur.keys[3];
					report_if.key_slot_4 <= cur.keys[4];
					report_if.key_slot_5 <= cur.keys[5];
				end else begin
					report_if.valid <= 1'b0;
				end
			end
		end
		events_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		report_t    seen;
		key_event_t got;
		key_event_t want;
		if (report_if.valid && report_if.ready) begin
			seen.command   = report_if.command;
			seen.modifiers = report_if.modifiers;
			seen.keys      = {report_if.key_slot_5, report_if.key_slot_4,
				report_if.key_slot_3, report_if.key_slot_2,
				report_if.key_slot_1, report_if.key_slot_0};
			predict_key_events(seen);
			report_taken = 1;
		end
		if (events_if.valid && events_if.ready) begin
			got = '{events_if.scancode, events_if.pressed, events_if.last_event};
			if (expected_events.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected event: scancode=%h pressed=%b last_event=%b",
						got.scancode, got.pressed, got.last_event);
				end
			end else begin
				want = expected_events.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= 10) begin
						$display({"event mismatch: expected scancode=%h pressed=%b last=%b,",
							" got scancode=%h pressed=%b last=%b"},
							want.scancode, want.pressed, want.last_event,
							got.scancode, got.pressed, got.last_event);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		report_t gen_prev;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		report_if.valid      = 1'b0;
		report_if.command    = CMD_REPORT;
		report_if.modifiers  = '0;
		report_if.key_slot_0 = '0;
		report_if.key_slot_1 = '0;
		report_if.key_slot_2 = '0;
		report_if.key_slot_3 = '0;
		report_if.key_slot_4 = '0;
		report_if.key_slot_5 = '0;
		events_if.ready      = 1'b0;
		held_modifiers       = '0;
		held_keys            = '0;
		report_taken         = 0;
		error_count          = 0;
		sender_idle_pct      = 0;
		receiver_stall_pct   = 0;
		gen_prev             = '0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// no change after reset
		queue_report(CMD_REPORT, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'h01, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'hFF, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
		// twenty events: all modifiers, six releases, six presses
		queue_report(CMD_REPORT, 8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
		queue_report(CMD_REPORT, 8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
		// unmapped usages give nothing
		queue_report(CMD_REPORT, 8'h80, 8'd0, 8'd1, 8'd2, 8'd3, 8'd111, 8'd112);
		queue_report(CMD_REPORT, 8'h80, 8'd255, 8'd128, 8'd127, 8'd98, 8'd97, 8'd96);
		queue_report(CMD_REPORT, 8'h80, 8'd3, 8'd112, 8'd0, 8'd0, 8'd0, 8'd0);
		// repeated usage in two slots
		queue_report(CMD_REPORT, 8'h80, 8'd30, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'h80, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'h80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'h55, 8'd0, 8'd0, 8'd0, 8'd0, 8'd40, 8'd40);
		// clear ignores the payload
		queue_report(CMD_CLEAR, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_report(CMD_REPORT, 8'h55, 8'd0, 8'd0, 8'd0, 8'd0, 8'd40, 8'd40);
		queue_report(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_report(CMD_REPORT, 8'hAA, 8'd101, 8'd99, 8'd82, 8'd83, 8'd84, 8'd85);
		queue_report(CMD_REPORT, 8'h5A, 8'd85, 8'd84, 8'd83, 8'd82, 8'd99, 8'd101);
		gen_prev.command   = CMD_REPORT;
		gen_prev.modifiers = 8'h5A;
		gen_prev.keys      = {8'd101, 8'd99, 8'd82, 8'd83, 8'd84, 8'd85};

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1:       begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
				2:       begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
				default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				gen_prev = next_report(gen_prev);
				pending_reports.push_back(gen_prev);
				if (gen_prev.command == CMD_CLEAR) begin
					gen_prev = '0;
				end
			end
			while (pending_reports.size() > 0 || report_if.valid || expected_events.size() > 0)
				@(negedge clk);
		end

		// a trailing report may give no event while the block is still busy
		repeat (40) @(negedge clk);
		if (error_count == 0 && expected_events.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
